>>> rtl/rpn_pkg.sv
// Shared constants, codes and control types of the postfix expression evaluator.
// No dependencies; every other file of the block imports this package.
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam int OP_W   = 3;
	localparam int DATA_W = 16;
	localparam int RES_W  = 32;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_REM  = 3'd5;
	localparam logic [OP_W-1:0] OP_POW  = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DIV0 = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

	localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_token;
		logic push;
		logic set_bad;
		logic start;
		logic commit;
		logic finish;
	} rpn_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            last;
		logic            err;
		logic            full;
		logic            short_stack;
		logic            alu_done;
	} rpn_stat_t;

	// True when a wide result is representable as a signed stack entry.
	function automatic logic fits_data(input logic signed [RES_W-1:0] v);
		return (&v[RES_W-1:DATA_W-1]) | ~(|v[RES_W-1:DATA_W-1]);
	endfunction

endpackage

>>> rtl/rpn_tok_if.sv
// Token channel of the postfix expression evaluator: valid/ready plus one token.
// Depends on rpn_pkg for the field widths.
interface rpn_tok_if;
	import rpn_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] operand_value;
	logic                     last_token;

	modport source (output valid, output operation, output operand_value, output last_token,
		input ready);
	modport sink (input valid, input operation, input operand_value, input last_token,
		output ready);
endinterface

>>> rtl/rpn_res_if.sv
// Result channel of the postfix expression evaluator: valid/ready plus one result.
// Depends on rpn_pkg for the field widths.
interface rpn_res_if;
	import rpn_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] result_value;
	logic [STAT_W-1:0]       status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

>>> rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator over a 16-bit signed value stack.
// The tokens channel carries one item per token: an operation code, an operand
// value used by pushes, and a flag marking the last token of an expression.
// The results channel carries one item per expression: the top of the stack
// (or the failing value) and a status code.
// A push passes through the dispatch state before the next token is taken; add,
// subtract and multiply, and a divide or remainder by zero, also wait in the
// execute state for the arithmetic unit; any other divide or remainder runs the
// one-bit-per-cycle divider; power runs the multiply loop, which stops early once
// the product saturates. A last token's finish state loads the result register.
// A result register parts the two channels: tokens of the next expression are
// taken while a result waits, but a second last token waits until the first
// result has been taken.
// Reset empties the stack, clears the error and drops any pending result; the
// stack memory itself is not cleared, as entries above the fill count are
// never used.
// Depends on rpn_pkg, rpn_tok_if, rpn_res_if, rpn_ctrl and rpn_dp.
module postfix_expression_evaluator (
	input logic       clk,
	input logic       arst_n,
	rpn_tok_if.sink   tokens,
	rpn_res_if.source results
);
	import rpn_pkg::*;

	rpn_cmd_t  cmd;
	rpn_stat_t stat;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tokens.valid),
		.tok_ready (tokens.ready),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rpn_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (tokens.operation),
		.operand_value (tokens.operand_value),
		.last_token    (tokens.last_token),
		.cmd           (cmd),
		.stat          (stat),
		.result_value  (results.result_value),
		.status        (results.status)
	);

endmodule

>>> rtl/rpn_alu.sv
// Arithmetic unit of the evaluator: registered add, subtract and multiply,
// a restoring divider and a saturating power loop. Depends on rpn_pkg.
module rpn_alu (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rpn_pkg::OP_W-1:0]         op,
	input  logic signed [rpn_pkg::DATA_W-1:0] lhs,
	input  logic signed [rpn_pkg::DATA_W-1:0] rhs,
	output logic                             done,
	output logic signed [rpn_pkg::RES_W-1:0] res,
	output logic                             div0
);
	import rpn_pkg::*;

	typedef enum logic [1:0] {A_IDLE, A_DIV, A_DIVFIX, A_POW} alu_state_t;

	localparam int BITCNT_W = $clog2(DATA_W + 1);

	alu_state_t                state_q;
	logic                      done_q;
	logic                      div0_q;
	logic signed [RES_W-1:0]   res_q;
	logic                      lhs_neg_q;
	logic                      rhs_neg_q;
	logic                      is_rem_q;
	logic [DATA_W-1:0]         quo_q;
	logic [DATA_W-1:0]         rem_q;
	logic [DATA_W-1:0]         divisor_q;
	logic [BITCNT_W-1:0]       bit_cnt_q;
	logic signed [RES_W-1:0]   acc_q;
	logic signed [DATA_W-1:0]  base_q;
	logic [DATA_W-2:0]         exp_q;

	logic signed [RES_W-1:0]        lhs_x;
	logic signed [RES_W-1:0]        rhs_x;
	logic signed [RES_W-1:0]        mul_res;
	logic [DATA_W-1:0]              lhs_mag;
	logic [DATA_W-1:0]              rhs_mag;
	logic [DATA_W:0]                shifted;
	logic                           take;
	logic signed [RES_W+DATA_W-1:0] prod;
	logic signed [RES_W-1:0]        quo_x;
	logic signed [RES_W-1:0]        rem_x;

	assign lhs_x   = {{(RES_W-DATA_W){lhs[DATA_W-1]}}, lhs};
	assign rhs_x   = {{(RES_W-DATA_W){rhs[DATA_W-1]}}, rhs};
	assign mul_res = lhs * rhs;
	assign lhs_mag = lhs[DATA_W-1] ? (~lhs + DATA_W'(1)) : lhs;
	assign rhs_mag = rhs[DATA_W-1] ? (~rhs + DATA_W'(1)) : rhs;

	// One quotient bit per cycle; the partial remainder stays below the divisor.
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign take    = shifted >= {1'b0, divisor_q};

	assign prod  = acc_q * base_q;
	assign quo_x = {{(RES_W-DATA_W){1'b0}}, quo_q};
	assign rem_x = {{(RES_W-DATA_W){1'b0}}, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= A_IDLE;
			done_q    <= 1'b0;
			div0_q    <= 1'b0;
			res_q     <= '0;
			lhs_neg_q <= 1'b0;
			rhs_neg_q <= 1'b0;
			is_rem_q  <= 1'b0;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			bit_cnt_q <= '0;
			acc_q     <= '0;
			base_q    <= '0;
			exp_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (start) begin
						div0_q <= 1'b0;
						case (op)
							OP_ADD: begin
								res_q  <= lhs_x + rhs_x;
								done_q <= 1'b1;
							end
							OP_SUB: begin
								res_q  <= lhs_x - rhs_x;
								done_q <= 1'b1;
							end
							OP_MUL: begin
								res_q  <= mul_res;
								done_q <= 1'b1;
							end
							OP_DIV, OP_REM: begin
								if (rhs == '0) begin
									div0_q <= 1'b1;
									res_q  <= '0;
									done_q <= 1'b1;
								end else begin
									lhs_neg_q <= lhs[DATA_W-1];
									rhs_neg_q <= rhs[DATA_W-1];
									is_rem_q  <= (op == OP_REM);
									quo_q     <= lhs_mag;
									rem_q     <= '0;
									divisor_q <= rhs_mag;
									bit_cnt_q <= BITCNT_W'(DATA_W);
									state_q   <= A_DIV;
								end
							end
							OP_POW: begin
								if (lhs == DATA_W'(1)) begin
									res_q  <= RES_W'(1);
									done_q <= 1'b1;
								end else if (lhs == '1) begin
									res_q  <= rhs[0] ? '1 : RES_W'(1);
									done_q <= 1'b1;
								end else if (lhs == '0) begin
									// Zero to a negative power saturates to the largest positive result.
									if (rhs[DATA_W-1]) begin
										res_q <= RES_MAX;
									end else begin
										res_q <= (rhs == '0) ? RES_W'(1) : '0;
									end
									done_q <= 1'b1;
								end else if (rhs[DATA_W-1]) begin
									res_q  <= '0;
									done_q <= 1'b1;
								end else begin
									acc_q   <= RES_W'(1);
									base_q  <= lhs;
									exp_q   <= rhs[DATA_W-2:0];
									state_q <= A_POW;
								end
							end
							default: begin
								res_q  <= '0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				A_DIV: begin
					if (take) begin
						rem_q <= DATA_W'(shifted - {1'b0, divisor_q});
					end else begin
						rem_q <= shifted[DATA_W-1:0];
					end
					quo_q     <= {quo_q[DATA_W-2:0], take};
					bit_cnt_q <= bit_cnt_q - BITCNT_W'(1);
					if (bit_cnt_q == BITCNT_W'(1)) begin
						state_q <= A_DIVFIX;
					end
				end
				A_DIVFIX: begin
					// The quotient is truncated toward zero; the remainder takes the
					// sign of the dividend.
					if (is_rem_q) begin
						res_q <= lhs_neg_q ? -rem_x : rem_x;
					end else begin
						res_q <= (lhs_neg_q ^ rhs_neg_q) ? -quo_x : quo_x;
					end
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				A_POW: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else if (prod > RES_MAX) begin
						res_q   <= RES_MAX;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else if (prod < RES_MIN) begin
						res_q   <= RES_MIN;
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						acc_q <= prod[RES_W-1:0];
						exp_q <= exp_q - (DATA_W-1)'(1);
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
	assign div0 = div0_q;

endmodule

>>> rtl/rpn_dp.sv
// Datapath of the evaluator: token register, value stack memory, top-of-stack,
// sticky error, arithmetic unit and result register. Depends on rpn_pkg, rpn_alu.
module rpn_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [rpn_pkg::OP_W-1:0]          operation,
	input  logic signed [rpn_pkg::DATA_W-1:0] operand_value,
	input  logic                              last_token,
	input  rpn_pkg::rpn_cmd_t                 cmd,
	output rpn_pkg::rpn_stat_t                stat,
	output logic signed [rpn_pkg::RES_W-1:0]  result_value,
	output logic [rpn_pkg::STAT_W-1:0]        status
);
	import rpn_pkg::*;

	logic [OP_W-1:0]          op_q;
	logic signed [DATA_W-1:0] operand_q;
	logic                     last_q;
	logic [CNT_W-1:0]         count_q;
	logic [STAT_W-1:0]        err_q;
	logic signed [RES_W-1:0]  err_val_q;
	logic signed [DATA_W-1:0] tos_q;
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [RES_W-1:0]  out_value_q;
	logic [STAT_W-1:0]        out_status_q;

	logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];

	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     wr_en;
	logic                     alu_done;
	logic signed [RES_W-1:0]  alu_res;
	logic                     alu_div0;
	logic                     commit_ok;

	rpn_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (op_q),
		.lhs    (rdata_q),
		.rhs    (tos_q),
		.done   (alu_done),
		.res    (alu_res),
		.div0   (alu_div0)
	);

	// The entry below the top is read every cycle; the top itself lives in tos_q.
	assign rd_addr   = count_q[ADDR_W-1:0] - ADDR_W'(2);
	assign commit_ok = cmd.commit & ~alu_div0 & fits_data(alu_res);
	assign wr_en     = cmd.push | commit_ok;
	assign wr_addr   = cmd.push ? count_q[ADDR_W-1:0] : rd_addr;
	assign wr_data   = cmd.push ? operand_q : alu_res[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rdata_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_token) begin
			op_q      <= operation;
			operand_q <= operand_value;
			last_q    <= last_token;
		end
		if (cmd.push) begin
			tos_q <= operand_q;
		end else if (commit_ok) begin
			tos_q <= alu_res[DATA_W-1:0];
		end
		if (cmd.finish) begin
			if (err_q != ST_OK) begin
				out_status_q <= err_q;
				out_value_q  <= err_val_q;
			end else if (count_q == '0) begin
				out_status_q <= ST_BAD;
				out_value_q  <= '0;
			end else begin
				out_status_q <= ST_OK;
				out_value_q  <= {{(RES_W-DATA_W){tos_q[DATA_W-1]}}, tos_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			err_q     <= ST_OK;
			err_val_q <= '0;
		end else if (cmd.finish) begin
			count_q   <= '0;
			err_q     <= ST_OK;
			err_val_q <= '0;
		end else if (cmd.set_bad) begin
			err_q     <= ST_BAD;
			err_val_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.commit) begin
			if (alu_div0) begin
				err_q     <= ST_DIV0;
				err_val_q <= '0;
			end else if (!fits_data(alu_res)) begin
				err_q     <= ST_OVF;
				err_val_q <= alu_res;
			end else begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		stat.op          = op_q;
		stat.last        = last_q;
		stat.err         = (err_q != ST_OK);
		stat.full        = (count_q == CNT_W'(STACK_DEPTH));
		stat.short_stack = (count_q < CNT_W'(2));
		stat.alu_done    = alu_done;
	end

	assign result_value = out_value_q;
	assign status       = out_status_q;

endmodule

>>> rtl/rpn_ctrl.sv
// Controller of the evaluator: token handshake, per-token sequencing and the
// result valid flag. Depends on rpn_pkg for command and status types.
module rpn_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output rpn_pkg::rpn_cmd_t  cmd,
	input  rpn_pkg::rpn_stat_t stat
);
	import rpn_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DISPATCH, S_EXEC, S_FINISH} state_t;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					cmd.load_token = 1'b1;
					state_d        = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = stat.last ? S_FINISH : S_IDLE;
				// After the first error the remaining tokens are dropped.
				if (stat.err) begin
					cmd = '0;
				end else if (stat.op == OP_PUSH) begin
					if (stat.full) begin
						cmd.set_bad = 1'b1;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (stat.op > OP_POW || stat.short_stack) begin
					cmd.set_bad = 1'b1;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.alu_done) begin
					cmd.commit = 1'b1;
					state_d    = stat.last ? S_FINISH : S_IDLE;
				end
			end
			S_FINISH: begin
				if (!res_valid_q || res_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign tok_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

endmodule

>>> rtl/rpn_checker.sv
// Port-level assertions for the postfix expression evaluator, bound to the top.
// Depends on rpn_pkg and postfix_expression_evaluator.
module rpn_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             tok_valid,
	input logic                             tok_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [rpn_pkg::RES_W-1:0] res_value,
	input logic [rpn_pkg::STAT_W-1:0]       res_status
);
	import rpn_pkg::*;

	// A result that is not taken holds its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_status))
		else $error("result changed while stalled");

	// A token is decoded in the dispatch state before the next one is taken.
	a_tok_gap: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready |=> !tok_ready)
		else $error("token taken on back-to-back cycles");

	// A good result is a stack entry, so it fits in 16 signed bits.
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == ST_OK |-> fits_data(res_value))
		else $error("good result outside the stack range");

	// Division by zero and malformed expressions report a zero value, and an
	// overflow reports a value that does not fit the stack.
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_OK |->
			((res_status == ST_OVF) ? !fits_data(res_value) : (res_value == '0)))
		else $error("error result carries a wrong value");

endmodule

bind postfix_expression_evaluator rpn_checker u_rpn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_value  (results.result_value),
	.res_status (results.status)
);

>>> dv/postfix_expression_evaluator_test.sv
`timescale 1ns / 1ps
// Testbench of the postfix expression evaluator: directed and random token streams,
// with each result checked against a stack model in the bench or a typed value.
// Depends on rpn_pkg, rpn_tok_if, rpn_res_if and postfix_expression_evaluator.
module postfix_expression_evaluator_test;
	import rpn_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int TOKEN_TARGET = 1350;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic [STAT_W-1:0]       status;
	} outcome_t;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] val;
		logic                     last;
		bit                       typed;
		logic signed [RES_W-1:0]  want_value;
		logic [STAT_W-1:0]        want_status;
	} token_row_t;

	typedef struct {
		bit       typed;
		outcome_t want;
	} pin_t;

	logic clk = 1'b0;
	logic arst_n;

	rpn_tok_if token_bus ();
	rpn_res_if result_bus ();

	postfix_expression_evaluator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.tokens  (token_bus),
		.results (result_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stack model of the block.
	logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH];
	int                       shadow_depth = 0;
	logic [STAT_W-1:0]        shadow_err = ST_OK;
	logic signed [RES_W-1:0]  shadow_err_value = '0;

	outcome_t   pending_outcomes [$];
	pin_t       last_token_pins [$];
	token_row_t staged [$];

	int  items_sent = 0;
	int  mismatch_count = 0;
	int  cycle_count = 0;
	int  drain_stall = 0;
	bit  feed_quiet = 1'b0;
	bit  drain_quiet = 1'b0;
	bit  hold_results = 1'b0;

	// Directed expressions; typed results are those that follow directly from the rules.
	token_row_t directed_rows [26] = '{
		'{OP_PUSH, 16'sd5, 1'b1, 1'b1, 32'sd5, ST_OK},
		'{OP_ADD, 16'sd0, 1'b1, 1'b1, 32'sd0, ST_BAD},
		'{OP_UNUSED, 16'sd0, 1'b1, 1'b1, 32'sd0, ST_BAD},
		'{OP_PUSH, 16'sh8000, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'shFFFF, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_DIV, 16'sd0, 1'b1, 1'b1, 32'sd32768, ST_OVF},
		'{OP_PUSH, 16'sd7, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd0, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_REM, 16'sd0, 1'b1, 1'b1, 32'sd0, ST_DIV0},
		'{OP_PUSH, 16'sd9, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd0, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_DIV, 16'sd0, 1'b1, 1'b1, 32'sd0, ST_DIV0},
		'{OP_PUSH, 16'sd0, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'shFFFF, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_POW, 16'sd0, 1'b1, 1'b1, RES_MAX, ST_OVF},
		'{OP_PUSH, 16'shFFFE, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd31, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_POW, 16'sd0, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd1, 1'b1, 1'b1, RES_MIN, ST_OVF},
		'{OP_PUSH, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sh8000, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_ADD, 16'sh7FFF, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd3, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_MUL, 16'sh8000, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_PUSH, 16'sd2, 1'b0, 1'b0, 32'sd0, ST_OK},
		'{OP_SUB, 16'shFFFF, 1'b1, 1'b0, 32'sd0, ST_OK}
	};

	function automatic longint power_saturated(input longint base, input longint expo);
		longint acc;
		acc = 1;
		if (expo < 0) begin
			if (base == 1) return 1;
			if (base == -1) return expo[0] ? -1 : 1;
			if (base == 0) return RES_MAX;
			return 0;
		end
		if (base == 0) return (expo == 0) ? 1 : 0;
		if (base == 1) return 1;
		if (base == -1) return expo[0] ? -1 : 1;
		for (longint i = 0; i < expo; i++) begin
			acc = acc * base;
			if (acc > RES_MAX) return RES_MAX;
			if (acc < RES_MIN) return RES_MIN;
		end
		return acc;
	endfunction

	function automatic void flag_error(input logic [STAT_W-1:0] code, input longint value);
		shadow_err = code;
		shadow_err_value = value[RES_W-1:0];
	endfunction

	function automatic void step_stack(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] val);
		longint lhs, rhs, res;
		if (op == OP_PUSH) begin
			if (shadow_depth >= STACK_DEPTH) begin
				flag_error(ST_BAD, 0);
				return;
			end
			shadow_stack[shadow_depth] = val;
			shadow_depth++;
			return;
		end
		if (op > OP_POW || shadow_depth < 2) begin
			flag_error(ST_BAD, 0);
			return;
		end
		rhs = shadow_stack[shadow_depth - 1];
		lhs = shadow_stack[shadow_depth - 2];
		shadow_depth -= 2;
		case (op)
			OP_ADD: res = lhs + rhs;
			OP_SUB: res = lhs - rhs;
			OP_MUL: res = lhs * rhs;
			OP_DIV: begin
				if (rhs == 0) begin
					flag_error(ST_DIV0, 0);
					return;
				end
				res = lhs / rhs;
			end
			OP_REM: begin
				if (rhs == 0) begin
					flag_error(ST_DIV0, 0);
					return;
				end
				res = lhs % rhs;
			end
			default: res = power_saturated(lhs, rhs);
		endcase
		if (res < -32768 || res > 32767) begin
			flag_error(ST_OVF, res);
			return;
		end
		shadow_stack[shadow_depth] = res[DATA_W-1:0];
		shadow_depth++;
	endfunction

	// Tokens after the first error are dropped; a last token yields the outcome and
	// clears the expression state.
	function automatic bit evaluate_token(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] val, input logic last, output outcome_t outcome);
		outcome.value = '0;
		outcome.status = ST_OK;
		if (shadow_err == ST_OK) step_stack(op, val);
		if (!last) return 1'b0;
		if (shadow_err != ST_OK) begin
			outcome.status = shadow_err;
			outcome.value = shadow_err_value;
		end else if (shadow_depth == 0) begin
			outcome.status = ST_BAD;
		end else begin
			outcome.value = shadow_stack[shadow_depth - 1];
		end
		shadow_depth = 0;
		shadow_err = ST_OK;
		shadow_err_value = '0;
		return 1'b1;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_operand();
		logic [DATA_W-1:0] raw;
		raw = DATA_W'($urandom);
		case ($urandom_range(0, 4))
			0, 1: raw = DATA_W'($urandom_range(0, 20) - 10);
			2: begin
				case ($urandom_range(0, 5))
					0: raw = 16'h8000;
					1: raw = 16'h8001;
					2: raw = 16'hFFFF;
					3: raw = 16'h0000;
					4: raw = 16'h0001;
					default: raw = 16'h7FFF;
				endcase
			end
			default: ;
		endcase
		return raw;
	endfunction

	function automatic logic [OP_W-1:0] rand_operator();
		case ($urandom_range(0, 5))
			0: return OP_ADD;
			1: return OP_SUB;
			2: return OP_MUL;
			3: return OP_DIV;
			4: return OP_REM;
			default: return OP_POW;
		endcase
	endfunction

	task automatic drive_token(input token_row_t row);
		int   gap;
		pin_t pin;
		gap = feed_quiet ? 0 : $urandom_range(0, 6);
		if (row.last) begin
			pin.typed = row.typed;
			pin.want.value = row.want_value;
			pin.want.status = row.want_status;
			last_token_pins.insert(last_token_pins.size(), pin);
		end
		if (gap > 0) begin
			token_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		token_bus.valid <= 1'b1;
		token_bus.operation <= row.op;
		token_bus.operand_value <= row.val;
		token_bus.last_token <= row.last;
		do @(posedge clk); while (!token_bus.ready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic void stage_token(input logic [OP_W-1:0] op,
			input logic signed [DATA_W-1:0] val);
		token_row_t row;
		row.op = op;
		row.val = val;
		row.last = 1'b0;
		row.typed = 1'b0;
		row.want_value = '0;
		row.want_status = ST_OK;
		staged.insert(staged.size(), row);
	endfunction

	task automatic send_staged();
		staged[staged.size() - 1].last = 1'b1;
		feed_quiet = ($urandom_range(0, 7) == 0);
		while (staged.size() != 0) drive_token(staged.pop_front());
	endtask

	// A valid expression with random content; now and then one operator too many.
	task automatic stage_wellformed();
		int ops_left, pushes_left, depth;
		ops_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 5);
		pushes_left = ops_left + 1 + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
		depth = 0;
		while (ops_left + pushes_left > 0) begin
			if (pushes_left > 0 && (depth < 2 || ops_left == 0 || $urandom_range(0, 1) == 0)) begin
				stage_token(OP_PUSH, rand_operand());
				pushes_left--;
				depth++;
			end else begin
				stage_token(rand_operator(), rand_operand());
				ops_left--;
				depth--;
			end
		end
		if ($urandom_range(0, 9) == 0) stage_token(rand_operator(), rand_operand());
	endtask

	task automatic stage_noise();
		int                n;
		logic [OP_W-1:0]   op;
		n = $urandom_range(1, 6);
		repeat (n) begin
			op = OP_W'($urandom_range(0, 7));
			stage_token(op, rand_operand());
		end
	endtask

	// Fills the stack to around its depth, past it on some runs.
	task automatic stage_deep();
		int pushes, ops;
		pushes = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
		ops = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, pushes - 1);
		repeat (pushes) stage_token(OP_PUSH, rand_operand());
		repeat (ops) stage_token(rand_operator(), rand_operand());
	endtask

	always @(posedge clk) begin : predict_tokens
		outcome_t outcome;
		pin_t     pin;
		if (arst_n && token_bus.valid && token_bus.ready) begin
			if (evaluate_token(token_bus.operation, token_bus.operand_value,
					token_bus.last_token, outcome)) begin
				pin = last_token_pins.pop_front();
				pending_outcomes.insert(pending_outcomes.size(), pin.typed ? pin.want : outcome);
			end
		end
	end

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: value %0d status %0d",
						result_bus.result_value, result_bus.status);
			end else begin
				want = pending_outcomes.pop_front();
				if (result_bus.result_value !== want.value || result_bus.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: value %0d status %0d, expected value %0d status %0d",
							result_bus.result_value, result_bus.status, want.value, want.status);
				end
			end
			if ($urandom_range(0, 19) == 0) drain_quiet = !drain_quiet;
			drain_stall = drain_quiet ? 0 : $urandom_range(0, 6);
		end
	end

	initial begin : drain_results
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (drain_stall > 0) begin
				drain_stall--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= !hold_results;
			end
		end
	end

	// One long hold on the result side so that tokens back up into the block.
	initial begin : hold_off_results
		wait (items_sent >= 400);
		@(posedge clk);
		hold_results = 1'b1;
		for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
		hold_results = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int expr_idx;
		token_bus.valid = 1'b0;
		token_bus.operation = OP_PUSH;
		token_bus.operand_value = '0;
		token_bus.last_token = 1'b0;
		arst_n = 1'b0;
		expr_idx = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) drive_token(directed_rows[i]);

		while (items_sent < TOKEN_TARGET) begin
			if (expr_idx % 40 == 20) stage_deep();
			else if ($urandom_range(0, 9) < 2) stage_noise();
			else stage_wellformed();
			send_staged();
			expr_idx++;
		end
		token_bus.valid <= 1'b0;

		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
